@@ src/hpcu_pkg.sv @@
// Shared types, codes and constants of the hodgepodge cell update engine.
package hpcu_pkg;

  localparam int DEF_GRID_SIDE = 32;

  // Field widths fixed by the cell format
  localparam int CELL_W = 8;
  localparam int SUM_W  = 12;
  localparam int CNT_W  = 4;
  localparam int DIV_W  = 4;

  // Divider: bits retired per cycle and cycles per division
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_STEPS;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_ILL_LEVEL        = 2'd0;
  localparam logic [1:0] REG_INFECTED_DIVISOR = 2'd1;
  localparam logic [1:0] REG_ILL_DIVISOR      = 2'd2;
  localparam logic [1:0] REG_INFECTION_RATE   = 2'd3;

  // Input item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Neighbourhood taps in read order
  localparam logic [3:0] TAP_CENTRE = 4'd0;
  localparam logic [3:0] TAP_WEST   = 4'd1;
  localparam logic [3:0] TAP_EAST   = 4'd2;
  localparam logic [3:0] TAP_NORTH  = 4'd3;
  localparam logic [3:0] TAP_SOUTH  = 4'd4;
  localparam logic [3:0] TAP_NW     = 4'd5;
  localparam logic [3:0] TAP_NE     = 4'd6;
  localparam logic [3:0] TAP_SW     = 4'd7;
  localparam logic [3:0] TAP_SE     = 4'd8;

  // Divider operand selection
  localparam logic [1:0] DSEL_AVG = 2'd0;
  localparam logic [1:0] DSEL_INF = 2'd1;
  localparam logic [1:0] DSEL_ILL = 2'd2;

  // Centre cell classes
  localparam logic [1:0] CLS_HEALTHY  = 2'd0;
  localparam logic [1:0] CLS_INFECTED = 2'd1;
  localparam logic [1:0] CLS_ILL      = 2'd2;

  typedef struct packed {
    logic [CELL_W-1:0] ill_level;
    logic [DIV_W-1:0]  infected_divisor;
    logic [DIV_W-1:0]  ill_divisor;
    logic [CELL_W-1:0] infection_rate;
  } cfg_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic       start;
    logic       rd_issue;
    logic [3:0] tap;
    logic       div_start;
    logic [1:0] div_sel;
    logic       cap_a;
    logic       cap_b;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic       clear_last;
    logic [1:0] centre_class;
    logic       div_done;
    logic       out_free;
  } status_t;

endpackage

@@ src/hodgepodge_cell_update.sv @@
// Top level of the hodgepodge cell update engine: ports, registers, wiring.
// A load item is taken straight from the idle state. An update item makes nine reads of the
// single-read-port bank, then no pass of the 4-bit-per-cycle divider for an ill centre, one for
// an infected one and two for a healthy one, then the commit once the output register is free.
// After rst the block clears both banks, one cell per cycle in each bank at once, over all
// GRID_SIDE*GRID_SIDE cells (1024 by default); items wait, config writes do not.
module hodgepodge_cell_update import hpcu_pkg::*; #(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  localparam int ADDR_W   = $clog2(GRID_SIDE * GRID_SIDE),
  localparam int IN_TD_W  = ((ADDR_W + CELL_W + 7) / 8) * 8,
  localparam int OUT_TD_W = ((CELL_W + SUM_W + ADDR_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // Item input
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_TD_W-1:0]  s_tdata,   // cell_address, cell_value, zero pad
  input  logic                s_tuser,   // kind
  // Result output
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_TD_W-1:0] m_tdata,   // new_value, neighbourhood_sum, updated_index
  output logic                m_tlast,   // sweep_done
  // Configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  cfg_t              cfg;
  cmd_t              cmd;
  status_t           status;
  logic              cfg_we;
  logic [1:0]        reg_idx;
  logic [CELL_W-1:0] new_value;
  logic [SUM_W-1:0]  neighbourhood_sum;
  logic [ADDR_W-1:0] updated_index;

  // Register file: write in the access phase, read back any time
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ill_level        <= CELL_W'(100);
      cfg.infected_divisor <= DIV_W'(2);
      cfg.ill_divisor      <= DIV_W'(3);
      cfg.infection_rate   <= CELL_W'(28);
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_ILL_LEVEL:        cfg.ill_level        <= pwdata[CELL_W-1:0];
        REG_INFECTED_DIVISOR: cfg.infected_divisor <= pwdata[DIV_W-1:0];
        REG_ILL_DIVISOR:      cfg.ill_divisor      <= pwdata[DIV_W-1:0];
        REG_INFECTION_RATE:   cfg.infection_rate   <= pwdata[CELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ILL_LEVEL:        prdata = PDATA_W'(cfg.ill_level);
      REG_INFECTED_DIVISOR: prdata = PDATA_W'(cfg.infected_divisor);
      REG_ILL_DIVISOR:      prdata = PDATA_W'(cfg.ill_divisor);
      REG_INFECTION_RATE:   prdata = PDATA_W'(cfg.infection_rate);
      default:              prdata = '0;
    endcase
  end

  // Sequencer: owns state and tap count, drives the datapath by commands
  hpcu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // Datapath: banks, accumulators, divider, output register
  hpcu_datapath #(
    .GRID_SIDE (GRID_SIDE)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg),
    .cell_address      (s_tdata[ADDR_W-1:0]),
    .cell_value        (s_tdata[ADDR_W+CELL_W-1:ADDR_W]),
    .m_tready          (m_tready),
    .m_tvalid          (m_tvalid),
    .new_value         (new_value),
    .neighbourhood_sum (neighbourhood_sum),
    .updated_index     (updated_index),
    .sweep_done        (m_tlast)
  );

  // Pack result fields from the lowest bit up, zero pad to whole bytes
  assign m_tdata = OUT_TD_W'({updated_index, neighbourhood_sum, new_value});

endmodule

@@ src/hpcu_div.sv @@
// Iterative restoring divider, several quotient bits per cycle.
module hpcu_div import hpcu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W:0]    rem;
  logic [SUM_W-1:0]  quo;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W:0]    rem_next;
  logic [SUM_W-1:0]  quo_next;

  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_next = {rem_next[DIV_W-1:0], quo_next[SUM_W-1]};
      quo_next = {quo_next[SUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dsr}) begin
        rem_next    = rem_next - {1'b0, dsr};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

@@ src/hpcu_datapath.sv @@
// Grid banks, neighbourhood accumulation, update rule and output register.
module hpcu_datapath import hpcu_pkg::*; #(
  parameter int GRID_SIDE = DEF_GRID_SIDE,
  localparam int ADDR_W   = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  cfg_t              cfg,
  input  logic [ADDR_W-1:0] cell_address,
  input  logic [CELL_W-1:0] cell_value,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [CELL_W-1:0] new_value,
  output logic [SUM_W-1:0]  neighbourhood_sum,
  output logic [ADDR_W-1:0] updated_index,
  output logic              sweep_done
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam logic [ADDR_W-1:0] SIDE_A     = ADDR_W'(GRID_SIDE);
  localparam logic [ADDR_W-1:0] SCAN_FIRST = ADDR_W'(GRID_SIDE + 1);
  localparam logic [ADDR_W-1:0] SCAN_LAST  = ADDR_W'(CELLS - GRID_SIDE - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);

  logic [CELL_W-1:0] bank_a [CELLS];
  logic [CELL_W-1:0] bank_b [CELLS];

  logic              active;
  logic [ADDR_W-1:0] scan;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] pos;
  logic [CELL_W-1:0] centre;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  ill_cnt;
  logic [CNT_W-1:0]  inf_cnt;
  logic              rd_valid;
  logic [3:0]        rd_tap;
  logic [CELL_W-1:0] rd_a;
  logic [CELL_W-1:0] rd_b;
  logic [SUM_W-1:0]  qa;
  logic [CNT_W-1:0]  qb;

  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] v;
  logic [CELL_W-1:0] q8;
  logic [CELL_W-1:0] top8;
  logic [1:0]        cls;
  logic              load_ok;
  logic              we_a, we_b;
  logic [ADDR_W-1:0] wa_a, wa_b;
  logic [CELL_W-1:0] wd_a, wd_b;
  logic [SUM_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [SUM_W-1:0]  div_quotient;
  logic              div_done;
  logic [4:0]        healthy_v;
  logic [CELL_W-1:0] nv_raw;
  logic [CELL_W-1:0] nv;
  logic              last_cell;
  logic [DIV_W-1:0]  k1, k2;

  assign q8   = (cfg.ill_level == '0) ? CELL_W'(1) : cfg.ill_level;
  assign top8 = q8 - 1'b1;
  assign k1   = (cfg.infected_divisor == '0) ? DIV_W'(1) : cfg.infected_divisor;
  assign k2   = (cfg.ill_divisor == '0) ? DIV_W'(1) : cfg.ill_divisor;

  // Neighbour address for the tap being issued
  always_comb begin
    unique case (cmd.tap)
      TAP_CENTRE: rd_addr = pos;
      TAP_WEST:   rd_addr = pos - 1'b1;
      TAP_EAST:   rd_addr = pos + 1'b1;
      TAP_NORTH:  rd_addr = pos - SIDE_A;
      TAP_SOUTH:  rd_addr = pos + SIDE_A;
      TAP_NW:     rd_addr = pos - SIDE_A - 1'b1;
      TAP_NE:     rd_addr = pos - SIDE_A + 1'b1;
      TAP_SW:     rd_addr = pos + SIDE_A - 1'b1;
      TAP_SE:     rd_addr = pos + SIDE_A + 1'b1;
      default:    rd_addr = pos;
    endcase
  end

  assign v = active ? rd_b : rd_a;

  // Write ports: clearing pass, load into active bank, result into the other
  assign load_ok = cmd.load && ({1'b0, cell_address} < (ADDR_W + 1)'(CELLS));

  always_comb begin
    we_a = 1'b0;
    wa_a = pos;
    wd_a = nv;
    we_b = 1'b0;
    wa_b = pos;
    wd_b = nv;
    priority if (cmd.clear) begin
      we_a = 1'b1; wa_a = clr_addr; wd_a = '0;
      we_b = 1'b1; wa_b = clr_addr; wd_b = '0;
    end else if (load_ok) begin
      if (active) begin
        we_b = 1'b1; wa_b = cell_address; wd_b = cell_value;
      end else begin
        we_a = 1'b1; wa_a = cell_address; wd_a = cell_value;
      end
    end else if (cmd.commit) begin
      we_a = active;
      we_b = !active;
    end
  end

  always_ff @(posedge clk) begin
    if (we_a) bank_a[wa_a] <= wd_a;
    rd_a <= bank_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) bank_b[wa_b] <= wd_b;
    rd_b <= bank_b[rd_addr];
  end

  // Centre classification
  always_comb begin
    if (centre == '0)      cls = CLS_HEALTHY;
    else if (centre < top8) cls = CLS_INFECTED;
    else                    cls = CLS_ILL;
  end

  // Divider operands
  always_comb begin
    unique case (cmd.div_sel)
      DSEL_AVG: begin
        div_dividend = sum;
        div_divisor  = inf_cnt + 1'b1;
      end
      DSEL_INF: begin
        div_dividend = SUM_W'(inf_cnt);
        div_divisor  = k1;
      end
      DSEL_ILL: begin
        div_dividend = SUM_W'(ill_cnt);
        div_divisor  = k2;
      end
      default: begin
        div_dividend = sum;
        div_divisor  = k1;
      end
    endcase
  end

  hpcu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Update rule and clamp
  assign healthy_v = {1'b0, qa[CNT_W-1:0]} + {1'b0, qb};

  always_comb begin
    unique case (cls)
      CLS_HEALTHY:  nv_raw = CELL_W'(healthy_v);
      CLS_INFECTED: nv_raw = qa[CELL_W-1:0] + cfg.infection_rate;
      default:      nv_raw = '0;
    endcase
    nv = (nv_raw > top8) ? top8 : nv_raw;
  end

  assign last_cell = (pos == SCAN_LAST);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      scan     <= SCAN_FIRST;
      clr_addr <= '0;
      rd_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_issue;
      if (cmd.clear) clr_addr <= clr_addr + 1'b1;
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
        scan     <= last_cell ? SCAN_FIRST : pos + 1'b1;
        active   <= active ^ last_cell;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Accumulators and payload
  always_ff @(posedge clk) begin
    rd_tap <= cmd.tap;
    if (cmd.start) begin
      pos     <= (scan < SCAN_FIRST || scan > SCAN_LAST) ? SCAN_FIRST : scan;
      sum     <= '0;
      ill_cnt <= '0;
      inf_cnt <= '0;
    end else if (rd_valid) begin
      sum <= sum + SUM_W'(v);
      if (rd_tap == TAP_CENTRE) begin
        centre <= v;
      end else if (rd_tap == TAP_WEST || rd_tap == TAP_EAST ||
                   rd_tap == TAP_NORTH || rd_tap == TAP_SOUTH) begin
        if (v == top8)     ill_cnt <= ill_cnt + 1'b1;
        else if (v != '0)  inf_cnt <= inf_cnt + 1'b1;
      end else begin
        if (v == q8)       ill_cnt <= ill_cnt + 1'b1;
        else if (v != '0)  inf_cnt <= inf_cnt + 1'b1;
      end
    end
    if (cmd.cap_a) qa <= div_quotient;
    if (cmd.cap_b) qb <= div_quotient[CNT_W-1:0];
    if (cmd.commit) begin
      new_value         <= nv;
      neighbourhood_sum <= sum;
      updated_index     <= pos;
      sweep_done        <= last_cell;
    end
  end

  assign status.clear_last   = (clr_addr == CELL_LAST);
  assign status.centre_class = cls;
  assign status.div_done     = div_done;
  assign status.out_free     = !m_tvalid || m_tready;

endmodule

@@ src/hpcu_ctrl.sv @@
// Sequencer: clearing pass, item intake, tap reads, divisions, commit.
module hpcu_ctrl import hpcu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  input  logic    kind,
  input  status_t status,
  output logic    s_tready,
  output cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_TAIL   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_WAIT_A = 3'd5;
  localparam logic [2:0] ST_WAIT_B = 3'd6;
  localparam logic [2:0] ST_WRITE  = 3'd7;

  logic [2:0] state, state_next;
  logic [3:0] tap, tap_next;

  always_comb begin
    state_next = state;
    tap_next   = tap;
    cmd        = '0;
    cmd.tap    = tap;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (kind == KIND_UPDATE) begin
            cmd.start  = 1'b1;
            tap_next   = TAP_CENTRE;
            state_next = ST_READ;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        tap_next     = tap + 1'b1;
        if (tap == TAP_SE) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        unique case (status.centre_class)
          CLS_HEALTHY: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_INF;
            state_next    = ST_WAIT_A;
          end
          CLS_INFECTED: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_AVG;
            state_next    = ST_WAIT_A;
          end
          default: state_next = ST_WRITE;
        endcase
      end
      ST_WAIT_A: begin
        if (status.div_done) begin
          cmd.cap_a = 1'b1;
          if (status.centre_class == CLS_HEALTHY) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_ILL;
            state_next    = ST_WAIT_B;
          end else begin
            state_next = ST_WRITE;
          end
        end
      end
      ST_WAIT_B: begin
        if (status.div_done) begin
          cmd.cap_b  = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      tap   <= TAP_CENTRE;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

endmodule
